// ===== hdl/ttrs_pkg.sv =====
// Package: shared constants, types and helpers for the Thomsen-to-stiffness pipeline.
package ttrs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int TRIG_LAT = CORDIC_N + 2;

  localparam int SQRT_N = 30;
  localparam int RAD_W = 2 * SQRT_N;
  localparam int REM_W = SQRT_N + 2;

  localparam int FRONT_N = 4;
  localparam int BACK_N = 4;
  localparam int LAT_N = FRONT_N + SQRT_N + BACK_N;
  localparam int TDLY_N = SQRT_N - TRIG_LAT;

  localparam int ANG_W = 34;
  localparam int TRIG_W = 34;
  localparam int FW = 34;
  localparam int PW = FW + TRIG_W;
  localparam int SW = PW + 2;
  localparam int RW = SW - 30;

  localparam logic signed [35:0] DEG_TO_RAD = 36'sd12281662764;
  localparam logic signed [ANG_W-1:0] GAIN_INV = ANG_W'(64'sd652032874);

  typedef struct packed {
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] s2;
    logic signed [TRIG_W-1:0] sc;
    logic signed [TRIG_W-1:0] c4;
    logic signed [TRIG_W-1:0] s4;
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] p;
    logic signed [TRIG_W-1:0] q;
  } trig_t;

  typedef struct packed {
    logic               mode;
    logic               tnz;
    logic               neg;
    logic [15:0]        dens;
    logic [27:0]        a2;
    logic [27:0]        l2;
    logic signed [31:0] a;
    logic signed [31:0] o;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:  r = ANG_W'(64'sd843314857);
      5'd1:  r = ANG_W'(64'sd497837829);
      5'd2:  r = ANG_W'(64'sd263043837);
      5'd3:  r = ANG_W'(64'sd133525159);
      5'd4:  r = ANG_W'(64'sd67021687);
      5'd5:  r = ANG_W'(64'sd33543516);
      5'd6:  r = ANG_W'(64'sd16775851);
      5'd7:  r = ANG_W'(64'sd8388437);
      5'd8:  r = ANG_W'(64'sd4194283);
      5'd9:  r = ANG_W'(64'sd2097149);
      5'd10: r = ANG_W'(64'sd1048576);
      5'd11: r = ANG_W'(64'sd524288);
      5'd12: r = ANG_W'(64'sd262144);
      5'd13: r = ANG_W'(64'sd131072);
      5'd14: r = ANG_W'(64'sd65536);
      5'd15: r = ANG_W'(64'sd32768);
      5'd16: r = ANG_W'(64'sd16384);
      5'd17: r = ANG_W'(64'sd8192);
      5'd18: r = ANG_W'(64'sd4096);
      5'd19: r = ANG_W'(64'sd2048);
      5'd20: r = ANG_W'(64'sd1024);
      5'd21: r = ANG_W'(64'sd512);
      5'd22: r = ANG_W'(64'sd256);
      5'd23: r = ANG_W'(64'sd128);
      default: r = '0;
    endcase
    return r;
  endfunction

  // rounded Q.30 product
  function automatic logic signed [TRIG_W-1:0] qm(input logic signed [TRIG_W-1:0] a,
                                                  input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] m;
    logic signed [2*TRIG_W-1:0] rc;
    rc = '0;
    rc[29] = 1'b1;
    m = a * b;
    m = m + rc;
    return m[30 +: TRIG_W];
  endfunction

endpackage

// ===== hdl/thomsen_to_rotated_stiffness.sv =====
// Top level: Thomsen parameters to tilted 2D stiffness coefficients, fully pipelined.
// One region description enters per clock unless the pipeline is held; its coefficients
// leave after 4 front stages, 30 square-root stages and 4 rotation and rounding stages;
// the depth is set by the one-bit-per-stage square root of the c13 radicand, with the
// CORDIC and the trig products running alongside it. While a result waits on out_tready
// the whole pipeline holds and in_tready is low. Isotropic items give vp^2/vs^2 terms;
// a negative radicand in tilted mode gives error set and all coefficients zero.
module thomsen_to_rotated_stiffness import ttrs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vp[13:0] vs[27:14] epsilon[43:28] delta[59:44] gamma[75:60] tilt[91:76]
  // density[107:92], zero pad [111:108]
  input  logic [111:0] in_tdata,
  // mode[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // c11[35:0] c33[71:36] c13[107:72] c55[143:108] c15[179:144] c35[215:180]
  // c66[251:216] c44[287:252] c46[323:288] density_out[339:324], zero pad [343:340]
  output logic [343:0] out_tdata,
  // material_index[0] error[1]
  output logic [1:0]   out_tuser
);

  logic               en;
  logic [LAT_N-1:0]   v_r;

  // front stage 1
  logic               s1_mode_r, s1_tnz_r;
  logic [15:0]        s1_dens_r;
  logic [27:0]        s1_a2_r, s1_l2_r;
  logic signed [15:0] s1_eps_r, s1_del_r, s1_gam_r;
  logic signed [14:0] s1_tf_r;
  logic signed [16:0] tilt_x;
  logic signed [16:0] tf_nxt;

  // front stage 2
  logic               s2_mode_r, s2_tnz_r;
  logic [15:0]        s2_dens_r;
  logic [27:0]        s2_a2_r, s2_l2_r;
  logic signed [30:0] s2_epa_r, s2_k_r, s2_gl_r;
  logic signed [28:0] s2_d_r;
  logic signed [ANG_W-1:0] s2_z_r;
  logic signed [44:0] ep_c, dp_c, gp_c;
  logic signed [50:0] zp_c;

  // front stage 3
  logic               s3_mode_r, s3_tnz_r;
  logic [15:0]        s3_dens_r;
  logic [27:0]        s3_a2_r, s3_l2_r;
  logic signed [31:0] s3_a_r, s3_o_r, s3_dk_r;
  logic signed [28:0] s3_d_r;
  logic signed [ANG_W-1:0] s3_z_r;

  // front stage 4
  logic               s4_mode_r, s4_tnz_r;
  logic [15:0]        s4_dens_r;
  logic [27:0]        s4_a2_r, s4_l2_r;
  logic signed [31:0] s4_a_r, s4_o_r;
  logic signed [60:0] s4_r_r;
  logic signed [ANG_W-1:0] s4_z_r;
  side_t              side_nxt;
  logic [RAD_W-1:0]   rad_nxt;

  // middle
  side_t              side_r [SQRT_N];
  trig_t              trig_w;
  trig_t              trd_r [TDLY_N];
  logic [SQRT_N-1:0]  root_w;

  // back stages
  side_t              b1_side_r, b2_side_r, b3_side_r;
  trig_t              b1_trig_r, b2_trig_r;
  logic signed [FW-1:0] b1_base_r [6];
  logic signed [FW-1:0] b2_base_r [6];
  logic signed [FW-1:0] b3_base_r [6];
  logic signed [FW-1:0] b2_g_r, b2_h_r, b2_k_r, b2_m_r, b2_op_r;
  logic signed [TRIG_W-1:0] b2_sc4_r, b2_w_r, b2_qp_r;
  logic signed [PW-1:0] prod_r [19];
  logic signed [SW-1:0] sum_c [9];
  logic signed [SW-1:0] rnd30;
  logic signed [RW-1:0] rot_c [9];
  logic signed [35:0]   co_nxt [9];
  logic signed [35:0]   co_r [9];
  logic [15:0]          dens_r;
  logic                 mi_r, err_r;
  logic signed [FW-1:0] iso_a, iso_l, iso_f;

  function automatic logic signed [35:0] sat36(input logic signed [RW-1:0] v);
    logic ok;
    ok = (&v[RW-1:35]) || !(|v[RW-1:35]);
    if (ok) begin
      return v[35:0];
    end
    return v[RW-1] ? {1'b1, 35'b0} : {1'b0, {35{1'b1}}};
  endfunction

  assign en        = !v_r[LAT_N-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT_N-2:0], in_tvalid};
    end
  end

  // tilt folded into [-9000, 9000]
  always_comb begin
    tilt_x = 17'(signed'(in_tdata[91:76]));
    if (tilt_x > 17'sd27000) begin
      tf_nxt = tilt_x - 17'sd36000;
    end else if (tilt_x > 17'sd9000) begin
      tf_nxt = tilt_x - 17'sd18000;
    end else if (tilt_x < -17'sd27000) begin
      tf_nxt = tilt_x + 17'sd36000;
    end else if (tilt_x < -17'sd9000) begin
      tf_nxt = tilt_x + 17'sd18000;
    end else begin
      tf_nxt = tilt_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= in_tuser[0];
      s1_tnz_r  <= (in_tdata[91:76] != 16'd0);
      s1_dens_r <= in_tdata[107:92];
      s1_a2_r   <= 28'(in_tdata[13:0]) * 28'(in_tdata[13:0]);
      s1_l2_r   <= 28'(in_tdata[27:14]) * 28'(in_tdata[27:14]);
      s1_eps_r  <= in_tdata[43:28];
      s1_del_r  <= in_tdata[59:44];
      s1_gam_r  <= in_tdata[75:60];
      s1_tf_r   <= tf_nxt[14:0];
    end
  end

  // rnd(2*x*A, 15) == floor((x*A + 2^13) / 2^14)
  assign ep_c = s1_eps_r * $signed({1'b0, s1_a2_r});
  assign dp_c = s1_del_r * $signed({1'b0, s1_a2_r});
  assign gp_c = s1_gam_r * $signed({1'b0, s1_l2_r});
  assign zp_c = s1_tf_r * DEG_TO_RAD;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode_r <= s1_mode_r;
      s2_tnz_r  <= s1_tnz_r;
      s2_dens_r <= s1_dens_r;
      s2_a2_r   <= s1_a2_r;
      s2_l2_r   <= s1_l2_r;
      s2_epa_r  <= 31'((ep_c + 45'sd8192) >>> 14);
      s2_k_r    <= 31'((dp_c + 45'sd8192) >>> 14);
      s2_gl_r   <= 31'((gp_c + 45'sd8192) >>> 14);
      s2_d_r    <= $signed({1'b0, s1_a2_r}) - $signed({1'b0, s1_l2_r});
      s2_z_r    <= ANG_W'((zp_c + 51'sd32768) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode_r <= s2_mode_r;
      s3_tnz_r  <= s2_tnz_r;
      s3_dens_r <= s2_dens_r;
      s3_a2_r   <= s2_a2_r;
      s3_l2_r   <= s2_l2_r;
      s3_a_r    <= 32'($signed({1'b0, s2_a2_r})) + 32'(s2_epa_r);
      s3_o_r    <= 32'($signed({1'b0, s2_l2_r})) + 32'(s2_gl_r);
      s3_dk_r   <= 32'(s2_d_r) + 32'(s2_k_r);
      s3_d_r    <= s2_d_r;
      s3_z_r    <= s2_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mode_r <= s3_mode_r;
      s4_tnz_r  <= s3_tnz_r;
      s4_dens_r <= s3_dens_r;
      s4_a2_r   <= s3_a2_r;
      s4_l2_r   <= s3_l2_r;
      s4_a_r    <= s3_a_r;
      s4_o_r    <= s3_o_r;
      s4_r_r    <= s3_d_r * s3_dk_r;
      s4_z_r    <= s3_z_r;
    end
  end

  always_comb begin
    side_nxt.mode = s4_mode_r;
    side_nxt.tnz  = s4_tnz_r;
    side_nxt.neg  = s4_mode_r && s4_r_r[60];
    side_nxt.dens = s4_dens_r;
    side_nxt.a2   = s4_a2_r;
    side_nxt.l2   = s4_l2_r;
    side_nxt.a    = s4_a_r;
    side_nxt.o    = s4_o_r;
    rad_nxt       = s4_r_r[60] ? '0 : s4_r_r[RAD_W-1:0];
  end

  ttrs_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_in (rad_nxt),
    .root   (root_w)
  );

  ttrs_trig u_trig (
    .clk  (clk),
    .en   (en),
    .z_in (s4_z_r),
    .trig (trig_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < SQRT_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
      trd_r[0] <= trig_w;
      for (int k = 1; k < TDLY_N; k++) begin
        trd_r[k] <= trd_r[k-1];
      end
    end
  end

  // base order: a c f l o p
  always_ff @(posedge clk) begin
    if (en) begin
      b1_side_r    <= side_r[SQRT_N-1];
      b1_trig_r    <= trd_r[TDLY_N-1];
      b1_base_r[0] <= FW'(side_r[SQRT_N-1].a);
      b1_base_r[1] <= FW'($signed({1'b0, side_r[SQRT_N-1].a2}));
      b1_base_r[2] <= FW'($signed({1'b0, root_w})) - FW'($signed({1'b0, side_r[SQRT_N-1].l2}));
      b1_base_r[3] <= FW'($signed({1'b0, side_r[SQRT_N-1].l2}));
      b1_base_r[4] <= FW'(side_r[SQRT_N-1].o);
      b1_base_r[5] <= FW'($signed({1'b0, side_r[SQRT_N-1].l2}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_side_r <= b1_side_r;
      b2_trig_r <= b1_trig_r;
      b2_base_r <= b1_base_r;
      b2_g_r    <= (b1_base_r[2] <<< 1) + (b1_base_r[3] <<< 2);
      b2_h_r    <= b1_base_r[0] + b1_base_r[1] - (b1_base_r[3] <<< 2);
      b2_k_r    <= b1_base_r[0] + b1_base_r[1] - (b1_base_r[2] <<< 1);
      b2_m_r    <= b1_base_r[2] + (b1_base_r[3] <<< 1);
      b2_op_r   <= b1_base_r[4] - b1_base_r[5];
      b2_sc4_r  <= b1_trig_r.s4 + b1_trig_r.c4;
      b2_w_r    <= b1_trig_r.c4 + b1_trig_r.s4 - (b1_trig_r.x <<< 1);
      b2_qp_r   <= b1_trig_r.q - b1_trig_r.p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_side_r  <= b2_side_r;
      b3_base_r  <= b2_base_r;
      prod_r[0]  <= b2_base_r[0] * b2_trig_r.c4;
      prod_r[1]  <= b2_base_r[1] * b2_trig_r.s4;
      prod_r[2]  <= b2_g_r * b2_trig_r.x;
      prod_r[3]  <= b2_base_r[0] * b2_trig_r.s4;
      prod_r[4]  <= b2_base_r[1] * b2_trig_r.c4;
      prod_r[5]  <= b2_h_r * b2_trig_r.x;
      prod_r[6]  <= b2_base_r[2] * b2_sc4_r;
      prod_r[7]  <= b2_k_r * b2_trig_r.x;
      prod_r[8]  <= b2_base_r[3] * b2_w_r;
      prod_r[9]  <= b2_base_r[0] * b2_trig_r.p;
      prod_r[10] <= b2_base_r[1] * b2_trig_r.q;
      prod_r[11] <= b2_m_r * b2_qp_r;
      prod_r[12] <= b2_base_r[0] * b2_trig_r.q;
      prod_r[13] <= b2_base_r[1] * b2_trig_r.p;
      prod_r[14] <= b2_base_r[4] * b2_trig_r.c2;
      prod_r[15] <= b2_base_r[5] * b2_trig_r.s2;
      prod_r[16] <= b2_base_r[4] * b2_trig_r.s2;
      prod_r[17] <= b2_base_r[5] * b2_trig_r.c2;
      prod_r[18] <= b2_op_r * b2_trig_r.sc;
    end
  end

  always_comb begin
    rnd30 = '0;
    rnd30[29] = 1'b1;
    sum_c[0] = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    sum_c[1] = SW'(prod_r[3]) + SW'(prod_r[4]) + SW'(prod_r[2]);
    sum_c[2] = SW'(prod_r[5]) + SW'(prod_r[6]);
    sum_c[3] = SW'(prod_r[7]) + SW'(prod_r[8]);
    sum_c[4] = SW'(prod_r[9]) - SW'(prod_r[10]) + SW'(prod_r[11]);
    sum_c[5] = SW'(prod_r[12]) - SW'(prod_r[13]) - SW'(prod_r[11]);
    sum_c[6] = SW'(prod_r[14]) + SW'(prod_r[15]);
    sum_c[7] = SW'(prod_r[16]) + SW'(prod_r[17]);
    sum_c[8] = SW'(prod_r[18]);
    for (int i = 0; i < 9; i++) begin
      rot_c[i] = RW'((sum_c[i] + rnd30) >>> 30);
    end

    iso_a = FW'($signed({1'b0, b3_side_r.a2}));
    iso_l = FW'($signed({1'b0, b3_side_r.l2}));
    iso_f = iso_a - (iso_l <<< 1);

    for (int i = 0; i < 9; i++) begin
      co_nxt[i] = '0;
    end
    if (!b3_side_r.mode) begin
      co_nxt[0] = 36'(iso_a);
      co_nxt[1] = 36'(iso_a);
      co_nxt[2] = 36'(iso_f);
      co_nxt[3] = 36'(iso_l);
      co_nxt[6] = 36'(iso_l);
      co_nxt[7] = 36'(iso_l);
    end else if (b3_side_r.neg) begin
      for (int i = 0; i < 9; i++) begin
        co_nxt[i] = '0;
      end
    end else if (!b3_side_r.tnz) begin
      co_nxt[0] = 36'(b3_base_r[0]);
      co_nxt[1] = 36'(b3_base_r[1]);
      co_nxt[2] = 36'(b3_base_r[2]);
      co_nxt[3] = 36'(b3_base_r[3]);
      co_nxt[6] = 36'(b3_base_r[4]);
      co_nxt[7] = 36'(b3_base_r[5]);
    end else begin
      for (int i = 0; i < 9; i++) begin
        co_nxt[i] = sat36(rot_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_r   <= co_nxt;
      dens_r <= b3_side_r.dens;
      mi_r   <= b3_side_r.mode;
      err_r  <= b3_side_r.neg;
    end
  end

  assign out_tvalid = v_r[LAT_N-1];
  assign out_tdata  = {4'b0, dens_r, co_r[8], co_r[7], co_r[6], co_r[5], co_r[4],
                       co_r[3], co_r[2], co_r[1], co_r[0]};
  assign out_tuser  = {err_r, mi_r};

  a_err_tti: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("error flag on an isotropic item");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[323:0] == '0)
    else $error("nonzero coefficients with error flag");

  a_iso_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[215:144] == '0 && out_tdata[323:288] == '0)
    else $error("tilt terms on an isotropic item");

endmodule

// ===== hdl/ttrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ttrs_sqrt import ttrs_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  output logic [SQRT_N-1:0] root
);

  logic [REM_W-1:0]  rem_r  [SQRT_N-1];
  logic [RAD_W-1:0]  rad_r  [SQRT_N-1];
  logic [SQRT_N-1:0] root_r [SQRT_N];

  genvar k;
  for (k = 0; k < SQRT_N; k++) begin : g_st
    logic [REM_W-1:0]  rem_p;
    logic [RAD_W-1:0]  rad_p;
    logic [SQRT_N-1:0] root_p;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign rad_p  = rad_in;
      assign root_p = '0;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign root_p = root_r[k-1];
    end

    assign cur   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_p[SQRT_N-2:0], ge};
      end
    end

    if (k < SQRT_N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (cur - trial) : cur;
          rad_r[k] <= rad_p << 2;
        end
      end
    end
  end

  assign root = root_r[SQRT_N-1];

endmodule

// ===== hdl/ttrs_trig.sv =====
// Pipelined CORDIC rotator and the sine/cosine product terms of the tilt rotation.
module ttrs_trig import ttrs_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] z_in,
  output trig_t                   trig
);

  logic signed [ANG_W-1:0]  x_r [CORDIC_N];
  logic signed [ANG_W-1:0]  y_r [CORDIC_N];
  logic signed [ANG_W-1:0]  z_r [CORDIC_N-1];
  logic signed [TRIG_W-1:0] c2_r;
  logic signed [TRIG_W-1:0] s2_r;
  logic signed [TRIG_W-1:0] sc_r;
  trig_t                    trig_r;

  genvar k;
  for (k = 0; k < CORDIC_N; k++) begin : g_rot
    logic signed [ANG_W-1:0] xi;
    logic signed [ANG_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;

    if (k == 0) begin : g_first
      assign xi = GAIN_INV;
      assign yi = '0;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ANG_W-1]) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
        end
      end
    end

    if (k < CORDIC_N - 1) begin : g_ang
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[ANG_W-1]) begin
            z_r[k] <= zi - atan_q30(5'(k));
          end else begin
            z_r[k] <= zi + atan_q30(5'(k));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r      <= qm(x_r[CORDIC_N-1], x_r[CORDIC_N-1]);
      s2_r      <= qm(y_r[CORDIC_N-1], y_r[CORDIC_N-1]);
      sc_r      <= qm(y_r[CORDIC_N-1], x_r[CORDIC_N-1]);
      trig_r.c2 <= c2_r;
      trig_r.s2 <= s2_r;
      trig_r.sc <= sc_r;
      trig_r.c4 <= qm(c2_r, c2_r);
      trig_r.s4 <= qm(s2_r, s2_r);
      trig_r.x  <= qm(c2_r, s2_r);
      trig_r.p  <= qm(c2_r, sc_r);
      trig_r.q  <= qm(s2_r, sc_r);
    end
  end

  assign trig = trig_r;

endmodule

// ===== verif/thomsen_to_rotated_stiffness_tb.sv =====
// Testbench for thomsen_to_rotated_stiffness: predicted coefficients checked item by item.
module thomsen_to_rotated_stiffness_tb import ttrs_pkg::*;;

  localparam longint C36_HI = 64'sd34359738367;
  localparam longint C36_LO = -64'sd34359738368;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [35:0] c46, c44, c66, c35, c15, c55, c13, c33, c11;
    logic [15:0] dens;
    logic        idx;
    logic        err;
  } coeff_t;

  function automatic longint fsh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt64(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [35:0] sat36(longint v);
    if (v > C36_HI) return C36_HI[35:0];
    if (v < C36_LO) return C36_LO[35:0];
    return v[35:0];
  endfunction

  function automatic longint atan_tab(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic coeff_t stiffness(logic mode, logic [111:0] d);
    coeff_t r;
    longint vp, vs, eps, del, gam, tl, aa, ll, dd, kk, rr, a, c, f, l, o, p;
    longint z, x, y, nx, c2, s2, sc, c4, s4, xx, pp, qq;
    longint co[9];
    int n;
    vp = d[13:0]; vs = d[27:14];
    eps = $signed(d[43:28]); del = $signed(d[59:44]); gam = $signed(d[75:60]);
    tl = $signed(d[91:76]);
    aa = vp * vp; ll = vs * vs;
    foreach (co[i]) co[i] = 0;
    r = '0;
    r.dens = d[107:92];
    r.idx = mode;
    if (!mode) begin
      co[0] = aa; co[1] = aa; co[2] = aa - 2 * ll; co[3] = ll; co[6] = ll; co[7] = ll;
    end else begin
      dd = aa - ll;
      kk = rnd(2 * del * aa, 15);
      rr = dd * dd + kk * dd;
      if (rr < 0) begin
        r.err = 1'b1;
      end else begin
        a = aa + rnd(2 * eps * aa, 15); c = aa; f = isqrt64(rr) - ll; l = ll;
        o = ll + rnd(2 * gam * ll, 15); p = ll;
        if (tl == 0) begin
          co[0] = a; co[1] = c; co[2] = f; co[3] = l; co[6] = o; co[7] = p;
        end else begin
          while (tl > 9000) tl -= 18000;
          while (tl < -9000) tl += 18000;
          z = rnd(tl * 64'sd12281662764, 16);
          x = 652032874; y = 0;
          n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
          for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
              nx = x - fsh(y, i); y = y + fsh(x, i); z -= atan_tab(i);
            end else begin
              nx = x + fsh(y, i); y = y - fsh(x, i); z += atan_tab(i);
            end
            x = nx;
          end
          c2 = rnd(x * x, 30); s2 = rnd(y * y, 30); sc = rnd(y * x, 30);
          c4 = rnd(c2 * c2, 30); s4 = rnd(s2 * s2, 30); xx = rnd(c2 * s2, 30);
          pp = rnd(c2 * sc, 30); qq = rnd(s2 * sc, 30);
          co[0] = rnd(a * c4 + c * s4 + (2 * f + 4 * l) * xx, 30);
          co[1] = rnd(a * s4 + c * c4 + (2 * f + 4 * l) * xx, 30);
          co[2] = rnd((a + c - 4 * l) * xx + f * (s4 + c4), 30);
          co[3] = rnd((a + c - 2 * f) * xx + l * (c4 + s4 - 2 * xx), 30);
          co[4] = rnd(a * pp - c * qq + (f + 2 * l) * (qq - pp), 30);
          co[5] = rnd(a * qq - c * pp + (f + 2 * l) * (pp - qq), 30);
          co[6] = rnd(o * c2 + p * s2, 30);
          co[7] = rnd(o * s2 + p * c2, 30);
          co[8] = rnd((o - p) * sc, 30);
        end
      end
    end
    r.c11 = sat36(co[0]); r.c33 = sat36(co[1]); r.c13 = sat36(co[2]);
    r.c55 = sat36(co[3]); r.c15 = sat36(co[4]); r.c35 = sat36(co[5]);
    r.c66 = sat36(co[6]); r.c44 = sat36(co[7]); r.c46 = sat36(co[8]);
    return r;
  endfunction

  int n_errors = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  class stiffness_board;
    coeff_t pending[$];
    int n_checked;
    function void note_item(logic mode, logic [111:0] d);
      pending.push_back(stiffness(mode, d));
    endfunction
    task check_result(logic [343:0] d, logic [1:0] u);
      coeff_t w;
      logic [35:0] g[9];
      logic [35:0] e[9];
      if (pending.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      w = pending.pop_front();
      n_checked++;
      for (int i = 0; i < 9; i++) g[i] = d[36*i +: 36];
      e = '{w.c11, w.c33, w.c13, w.c55, w.c15, w.c35, w.c66, w.c44, w.c46};
      for (int i = 0; i < 9; i++)
        if (g[i] !== e[i]) report($sformatf("coeff %0d", i), g[i], e[i]);
      if (d[339:324] !== w.dens) report("density_out", d[339:324], w.dens);
      if (u[0] !== w.idx) report("material_index", u[0], w.idx);
      if (u[1] !== w.err) report("error", u[1], w.err);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [111:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tready, out_tvalid;
  logic [343:0] out_tdata;
  logic [1:0] out_tuser;
  int send_idle = 0, recv_idle = 0, n_cycles = 0, n_sent = 0;
  stiffness_board board = new();

  thomsen_to_rotated_stiffness u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    n_cycles++;
    if (rst_n && in_tvalid && in_tready) board.note_item(in_tuser[0], in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("thomsen_to_rotated_stiffness_tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= rst_n && ($urandom_range(99) >= recv_idle);

  // valid stays up after the accepting edge; the next send replaces the item or idles it low, and drain takes it down
  task automatic send(logic mode, logic [13:0] vp, logic [13:0] vs, logic [15:0] e,
                      logic [15:0] dl, logic [15:0] g, logic [15:0] t, logic [15:0] dn);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {4'b0, dn, t, g, dl, e, vs, vp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_tilt();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($signed($urandom_range(300)) - 150);
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(36000)) - 18000);
    endcase
  endfunction

  function automatic logic [15:0] rand_q15();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(8000)) - 4000);
  endfunction

  task automatic send_random();
    logic [13:0] vp, vs;
    vp = 14'($urandom);
    vs = ($urandom_range(4) == 0) ? 14'($urandom) : 14'($urandom_range(vp / 2));
    send($urandom_range(4) != 0, vp, vs, rand_q15(), rand_q15(), rand_q15(), rand_tilt(),
         16'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, both modes, zero and folded tilts, negative radicand
    send(0, 0, 0, 0, 0, 0, 0, 0);
    send(0, 14'h3fff, 14'h3fff, 16'h7fff, 16'h8000, 16'h7fff, 16'd9000, 16'hffff);
    send(0, 14'h3fff, 0, 0, 0, 0, 0, 16'h1234);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 0, 16'd2500);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 16'd4500, 16'd1);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, -16'sd4500, 16'd2);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 16'd9000, 16'd3);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, -16'sd9000, 16'd4);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 16'd18000, 16'd5);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, -16'sd18000, 16'd6);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 16'h7fff, 16'd7);
    send(1, 14'd3000, 14'd1500, 16'd3000, 16'd2000, 16'd1000, 16'h8000, 16'd8);
    send(1, 14'd3000, 14'd2900, 0, 16'h8000, 0, 16'd100, 16'd9);
    send(1, 14'h3fff, 14'h3fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd3000, 16'hffff);
    send(1, 14'h3fff, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd1, 16'd0);
    send(1, 14'h3fff, 0, 16'h8000, 16'h8000, 16'h8000, -16'sd1, 16'd0);
    send(1, 0, 14'h3fff, 16'h7fff, 16'h8000, 16'h7fff, 16'd6000, 16'd11);
    send(1, 0, 0, 0, 0, 0, 0, 0);
    send(1, 14'h3fff, 14'h3fff, 16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd12);
    drain();
    send_idle = 26; recv_idle = 61;
    repeat (600) send_random();
    drain();
    send_idle = 61; recv_idle = 26;
    repeat (600) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (630) send_random();
    drain();
    repeat (60) @(negedge clk);
    $display("sent %0d items, checked %0d results across both modes, folded tilts and",
             n_sent, board.n_checked);
    $display("negative radicands, under three idling patterns");
    if (n_errors == 0 && board.pending.size() == 0)
      $display("thomsen_to_rotated_stiffness_tb: done, clean");
    else
      $display("thomsen_to_rotated_stiffness_tb: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ttrs_pkg.sv
hdl/ttrs_sqrt.sv
hdl/ttrs_trig.sv
hdl/thomsen_to_rotated_stiffness.sv
verif/thomsen_to_rotated_stiffness_tb.sv
